/* rtl/krt_pkg.sv */
// Package for the range tracker: widths, reset values, state and command types.
// No dependencies.
package krt_pkg;
    localparam int Channels = 4;
    localparam int ChW = 2;
    localparam logic [31:0] PosInit = 32'sd13107200;
    localparam logic [31:0] OneQ16 = 32'sd65536;
    localparam logic [1:0] RegQpos = 2'd0;
    localparam logic [1:0] RegQvel = 2'd1;
    localparam logic [1:0] RegRmeas = 2'd2;
    localparam logic [1:0] RegDt = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_PRED, S_PRED2, S_DIVST, S_DIVRUN, S_GAIN1, S_UPD1, S_UPD2,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic pred;
        logic pred2;
        logic div_start;
        logic gain1;
        logic upd1;
        logic upd2;
        logic out_valid;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -66'sh80000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p >>> 16;
    endfunction
endpackage

/* rtl/krt_if.sv */
// Valid/ready channel carrying a payload of type T.
// Depends on nothing.
interface krt_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/krt_ctrl.sv */
// Sequencer for one filter step.
// Depends on krt_pkg.
module krt_ctrl import krt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_out_ready,
    input  t_stat  i_stat,
    output logic   o_in_ready,
    output t_cmd   o_cmd
);
    t_state r_state, n_state;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_LOAD;
            S_LOAD:   n_state = S_PRED;
            S_PRED:   n_state = S_PRED2;
            S_PRED2:  n_state = S_DIVST;
            S_DIVST:  n_state = S_DIVRUN;
            S_DIVRUN: if (i_stat.div_done) n_state = S_GAIN1;
            S_GAIN1:  n_state = S_UPD1;
            S_UPD1:   n_state = S_UPD2;
            S_UPD2:   n_state = S_OUT;
            S_OUT:    if (i_out_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end
    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE:   o_in_ready = 1'b1;
            S_LOAD:   o_cmd.load = 1'b1;
            S_PRED:   o_cmd.pred = 1'b1;
            S_PRED2:  o_cmd.pred2 = 1'b1;
            S_DIVST:  o_cmd.div_start = 1'b1;
            S_GAIN1:  o_cmd.gain1 = 1'b1;
            S_UPD1:   o_cmd.upd1 = 1'b1;
            S_UPD2:   o_cmd.upd2 = 1'b1;
            S_OUT:    o_cmd.out_valid = 1'b1;
            default:  o_cmd = '0;
        endcase
    end
endmodule

/* rtl/krt_dp.sv */
// Datapath: channel state, prediction, restoring divider, update.
// Depends on krt_pkg.
module krt_dp import krt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_take,
    input  logic [1:0]         i_channel,
    input  logic [15:0]        i_sample,
    input  logic [30:0]        i_qpos,
    input  logic [30:0]        i_qvel,
    input  logic [30:0]        i_rmeas,
    input  logic [15:0]        i_dt,
    output t_stat              o_stat,
    output logic signed [31:0] o_pos,
    output logic [1:0]         o_ch
);
    logic signed [31:0] r_x0 [Channels], r_x1 [Channels];
    logic signed [31:0] r_pp [Channels], r_pv [Channels], r_vp [Channels], r_vv [Channels];
    logic [1:0] r_ch;
    logic [15:0] r_z;
    logic signed [31:0] r_a0, r_a1, r_a2, r_a3, r_a4, r_a5;
    logic signed [31:0] r_x0p, r_p00, r_p01, r_p10, r_p11, r_k0, r_k1, r_inn;
    logic signed [63:0] r_m0, r_m1, r_m2, r_m3;
    logic signed [31:0] dts;
    logic signed [33:0] den;
    // two serial dividers sharing one denominator
    logic [48:0] r_n0, r_n1;
    logic [49:0] r_q0, r_q1;
    logic [49:0] r_rem0, r_rem1;
    logic [33:0] r_den;
    logic r_neg0, r_neg1, r_dz;
    logic [5:0] r_cnt;
    logic r_busy;
    logic [49:0] t0, t1;
    logic signed [50:0] sq0, sq1;

    assign dts = {16'd0, i_dt};
    assign den = 34'(r_p00) + 34'({1'b0, i_rmeas});
    assign t0 = {r_rem0[48:0], r_n0[48]};
    assign t1 = {r_rem1[48:0], r_n1[48]};
    assign sq0 = r_neg0 ? -$signed({1'b0, r_q0}) : $signed({1'b0, r_q0});
    assign sq1 = r_neg1 ? -$signed({1'b0, r_q1}) : $signed({1'b0, r_q1});
    assign o_stat.div_done = r_busy && (r_cnt == 6'd0);
    assign o_ch = r_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < Channels; c++) begin
                r_x0[c] <= PosInit; r_x1[c] <= OneQ16;
                r_pp[c] <= OneQ16; r_pv[c] <= OneQ16;
                r_vp[c] <= OneQ16; r_vv[c] <= OneQ16;
            end
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_take) begin
                r_ch <= i_channel;
                r_z <= i_sample;
            end
            if (i_cmd.load) begin
                r_a0 <= r_x0[r_ch]; r_a1 <= r_x1[r_ch]; r_a2 <= r_pp[r_ch];
                r_a3 <= r_pv[r_ch]; r_a4 <= r_vp[r_ch]; r_a5 <= r_vv[r_ch];
            end
            if (i_cmd.pred) begin
                r_m0 <= qmul(r_a1, dts); r_m1 <= qmul(r_a3, dts);
                r_m2 <= qmul(r_a4, dts); r_m3 <= qmul(r_a5, dts);
            end
            if (i_cmd.pred2) begin
                r_x0p <= sat32(66'(r_a0) + 66'(r_m0));
                r_p00 <= sat32(66'(r_a2) + 66'(r_m1) + 66'(r_m2) + 66'({1'b0, i_qpos}));
                r_p01 <= sat32(66'(r_a3) + 66'(r_m3));
                r_p10 <= sat32(66'(r_a4) + 66'(r_m3));
                r_p11 <= sat32(66'(r_a5) + 66'({1'b0, i_qvel}));
                r_inn <= sat32(66'($signed({2'b0, r_z, 16'd0}))
                               - 66'(sat32(66'(r_a0) + 66'(r_m0))));
            end
            if (i_cmd.div_start) begin
                r_dz <= (den == 0);
                r_den <= den[33] ? 34'(-den) : 34'(den);
                r_neg0 <= r_p00[31] ^ den[33];
                r_neg1 <= r_p10[31] ^ den[33];
                r_n0 <= 49'(r_p00[31] ? -48'(r_p00) : 48'(r_p00)) << 16;
                r_n1 <= 49'(r_p10[31] ? -48'(r_p10) : 48'(r_p10)) << 16;
                r_rem0 <= '0; r_rem1 <= '0; r_q0 <= '0; r_q1 <= '0;
                r_cnt <= 6'd49;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt != 0) begin
                    r_cnt <= r_cnt - 6'd1;
                    r_n0 <= r_n0 << 1; r_n1 <= r_n1 << 1;
                    if (t0 >= 50'(r_den)) begin
                        r_rem0 <= t0 - 50'(r_den); r_q0 <= {r_q0[48:0], 1'b1};
                    end else begin
                        r_rem0 <= t0; r_q0 <= {r_q0[48:0], 1'b0};
                    end
                    if (t1 >= 50'(r_den)) begin
                        r_rem1 <= t1 - 50'(r_den); r_q1 <= {r_q1[48:0], 1'b1};
                    end else begin
                        r_rem1 <= t1; r_q1 <= {r_q1[48:0], 1'b0};
                    end
                end else begin
                    r_busy <= 1'b0;
                end
            end
            if (i_cmd.gain1) begin
                r_k0 <= r_dz ? 32'sd0 : sat32(66'(sq0));
                r_k1 <= r_dz ? 32'sd0 : sat32(66'(sq1));
            end
            if (i_cmd.upd1) begin
                r_m0 <= qmul(r_k0, r_inn); r_m1 <= qmul(r_k1, r_inn);
                r_m2 <= qmul(r_k0, r_p00); r_m3 <= qmul(r_k0, r_p01);
            end
            if (i_cmd.upd2) begin
                r_x0[r_ch] <= sat32(66'(r_x0p) + 66'(r_m0));
                o_pos <= sat32(66'(r_x0p) + 66'(r_m0));
                r_x1[r_ch] <= sat32(66'(r_a1) + 66'(r_m1));
                r_pp[r_ch] <= sat32(66'(r_p00) - 66'(r_m2));
                r_pv[r_ch] <= sat32(66'(r_p01) - 66'(r_m3));
                r_vp[r_ch] <= sat32(66'(r_p10) - 66'(qmul(r_k1, r_p00)));
                r_vv[r_ch] <= sat32(66'(r_p11) - 66'(qmul(r_k1, r_p01)));
            end
        end
    end
endmodule

/* rtl/kalman_range_tracker_unit.sv */
// Top level of the range tracker: config registers, controller and datapath.
// Depends on krt_pkg, krt_if, krt_ctrl, krt_dp.
//
// Usage: i_in carries a request {channel, distance_sample}; o_out returns
// {filtered_distance, result_channel}, one result per request.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write one register per cycle;
// the user writes only while the block is idle (not enforced by the block).
// Most of the time from the accepting edge to result valid is spent in the
// 49-step restoring divider that forms both gains in parallel.
// One request is in flight at a time; the next is taken the cycle after
// the result is taken.
// Reset (synchronous, active low) restores every channel's state and the
// registers to their defaults. A stalled receiver holds the result and
// the block accepts nothing until it is taken.
module kalman_range_tracker_unit import krt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    krt_if.sink         i_in,
    krt_if.source       o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data
);
    logic [30:0] r_qpos, r_qvel, r_rmeas;
    logic [15:0] r_dt;
    t_cmd cmd;
    t_stat stat;
    logic in_rdy;
    logic signed [31:0] pos;
    logic [1:0] och;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qpos <= 31'd1966080; r_qvel <= 31'd32768;
            r_rmeas <= 31'd3932160; r_dt <= 16'd3932;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegQpos:  r_qpos <= i_cfg_data;
                RegQvel:  r_qvel <= i_cfg_data;
                RegRmeas: r_rmeas <= i_cfg_data;
                RegDt:    r_dt <= i_cfg_data[15:0];
                default:  r_dt <= r_dt;
            endcase
        end
    end

    assign i_in.ready = in_rdy;

    krt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in.valid),
        .i_out_ready(o_out.ready), .i_stat(stat), .o_in_ready(in_rdy), .o_cmd(cmd)
    );

    krt_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_take(i_in.valid && in_rdy),
        .i_channel(i_in.data[17:16]), .i_sample(i_in.data[15:0]),
        .i_qpos(r_qpos), .i_qvel(r_qvel), .i_rmeas(r_rmeas), .i_dt(r_dt),
        .o_stat(stat), .o_pos(pos), .o_ch(och)
    );

    assign o_out.valid = cmd.out_valid;
    assign o_out.data = {pos, och};
endmodule

/* tb/krt_tb_pkg.sv */
// Request and result payload types for the range tracker testbench.
// Depends on nothing; used by the checker and the testbench top.
`timescale 1ns / 100ps
package krt_tb_pkg;
    typedef struct packed {
        logic [1:0]  channel;
        logic [15:0] distance_sample;
    } req_t;

    typedef struct packed {
        logic [31:0] filtered_distance;
        logic [1:0]  result_channel;
    } rsp_t;
endpackage

/* tb/krt_tracker_checker.sv */
// Checker for the range tracker: mirrors the config registers, predicts the
// filtered position of every accepted request and compares each result.
// Depends on krt_pkg and krt_tb_pkg.
`timescale 1ns / 100ps
module krt_tracker_checker import krt_pkg::*, krt_tb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  req_t        i_req,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  rsp_t        i_rsp,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    int    pos [Channels];
    int    vel [Channels];
    int    cpp [Channels];
    int    cpv [Channels];
    int    cvp [Channels];
    int    cvv [Channels];
    longint q_pos, q_vel, r_meas, dt;
    rsp_t  expected_rsp [$];

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic longint fxmul(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> 16;
    endfunction

    function automatic int fxgain(int num, longint den);
        if (den == 0) return 0;
        return clamp32((longint'(num) * 65536) / den);
    endfunction

    function automatic rsp_t track_update(req_t rq);
        int c, x0, x1, p00, p01, p10, p11, k0, k1, innov;
        longint z, den;
        rsp_t r;
        c = int'(rq.channel);
        z = longint'(rq.distance_sample) * 65536;
        x0 = clamp32(longint'(pos[c]) + fxmul(vel[c], dt));
        x1 = vel[c];
        p00 = clamp32(longint'(cpp[c]) + fxmul(cpv[c], dt) + fxmul(cvp[c], dt) + q_pos);
        p01 = clamp32(longint'(cpv[c]) + fxmul(cvv[c], dt));
        p10 = clamp32(longint'(cvp[c]) + fxmul(cvv[c], dt));
        p11 = clamp32(longint'(cvv[c]) + q_vel);
        den = longint'(p00) + r_meas;
        k0 = fxgain(p00, den);
        k1 = fxgain(p10, den);
        innov = clamp32(z - longint'(x0));
        pos[c] = clamp32(longint'(x0) + fxmul(k0, innov));
        vel[c] = clamp32(longint'(x1) + fxmul(k1, innov));
        cpp[c] = clamp32(longint'(p00) - fxmul(k0, p00));
        cpv[c] = clamp32(longint'(p01) - fxmul(k0, p01));
        cvp[c] = clamp32(longint'(p10) - fxmul(k1, p00));
        cvv[c] = clamp32(longint'(p11) - fxmul(k1, p01));
        r.filtered_distance = pos[c];
        r.result_channel = rq.channel;
        return r;
    endfunction

    assign o_pending = expected_rsp.size();

    always @(posedge i_clk) begin
        rsp_t want;
        if (!i_rst_n) begin
            for (int c = 0; c < Channels; c++) begin
                pos[c] = PosInit;
                vel[c] = OneQ16;
                cpp[c] = OneQ16;
                cpv[c] = OneQ16;
                cvp[c] = OneQ16;
                cvv[c] = OneQ16;
            end
            q_pos = 1966080;
            q_vel = 32768;
            r_meas = 3932160;
            dt = 3932;
            o_errors = 0;
            o_results = 0;
            expected_rsp.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    RegQpos: q_pos = i_cfg_data;
                    RegQvel: q_vel = i_cfg_data;
                    RegRmeas: r_meas = i_cfg_data;
                    RegDt: dt = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready)
                expected_rsp.push_back(track_update(i_req));
            if (i_rsp_valid && i_rsp_ready) begin
                o_results++;
                if (expected_rsp.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: unexpected result ch %0d pos %0d", $realtime,
                                 i_rsp.result_channel, $signed(i_rsp.filtered_distance));
                end else begin
                    want = expected_rsp.pop_front();
                    if (want !== i_rsp) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("%0t: mismatch exp ch %0d pos %0d, got ch %0d pos %0d",
                                     $realtime, want.result_channel,
                                     $signed(want.filtered_distance), i_rsp.result_channel,
                                     $signed(i_rsp.filtered_distance));
                    end
                end
            end
        end
    end
endmodule

/* tb/kalman_range_tracker_unit_test.sv */
// Testbench top for the range tracker: drives requests, config writes and
// result back-pressure; the checker predicts and compares.
// Depends on krt_pkg, krt_if, krt_tb_pkg, krt_tracker_checker and the RTL.
`timescale 1ns / 100ps
module kalman_range_tracker_unit_test import krt_pkg::*, krt_tb_pkg::*; ();
    localparam int DrainCycles = 70;
    localparam int StallLimit = 4000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [30:0] cfg_data;
    int          idle_pct;
    int          stall_pct;
    int          errors, pending, results;
    int          quiet_cycles;
    int          sent;
    logic [15:0] last_dist [Channels];

    krt_if #(.T(req_t)) req_ch ();
    krt_if #(.T(rsp_t)) rsp_ch ();

    kalman_range_tracker_unit dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_in(req_ch), .o_out(rsp_ch),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    krt_tracker_checker checker_inst (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_req_valid(req_ch.valid), .i_req_ready(req_ch.ready), .i_req(req_ch.data),
        .i_rsp_valid(rsp_ch.valid), .i_rsp_ready(rsp_ch.ready), .i_rsp(rsp_ch.data),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("timeout with %0d results outstanding", pending);
            $display("kalman_range_tracker_unit_test NOT OK");
            $finish;
        end
    end

    task automatic send(input logic [1:0] ch, input logic [15:0] d);
        if ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= '{channel: ch, distance_sample: d};
        do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
        last_dist[ch] = d;
        sent++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic set_regs(input logic [30:0] qp, input logic [30:0] qv,
                            input logic [30:0] rm, input logic [30:0] st);
        logic [30:0] vals [4];
        vals = '{qp, qv, rm, st};
        for (int i = 0; i < 4; i++) begin
            cfg_we <= 1'b1;
            cfg_idx <= 2'(i);
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [1:0]  ch;
        logic [15:0] d;
        int          step;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        idle_pct = 0;
        stall_pct = 0;
        sent = 0;
        for (int c = 0; c < Channels; c++) last_dist[c] = 16'd200;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults, distance extremes, every channel
        for (int c = 0; c < Channels; c++) begin
            send(2'(c), 16'd200);
            send(2'(c), 16'd0);
            send(2'(c), 16'hFFFF);
        end
        send(2'd0, 16'd201);
        send(2'd1, 16'h8000);
        send(2'd2, 16'h7FFF);
        send(2'd3, 16'h5555);
        drain();
        set_regs(31'd0, 31'd0, 31'd1, 31'd0);
        send(2'd0, 16'hFFFF);
        send(2'd0, 16'd0);
        send(2'd3, 16'hAAAA);
        drain();
        set_regs(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
        send(2'd1, 16'hFFFF);
        send(2'd1, 16'd0);
        send(2'd2, 16'd1);

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            case (ph)
                0: set_regs(31'd1966080, 31'd32768, 31'd3932160, 31'd3932);
                1: set_regs(31'd0, 31'd0, 31'd1, 31'h7FFF0000);
                2: set_regs(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h0000FFFF);
                default: set_regs(31'($urandom_range(0, 32'h00FFFFFF)),
                                  31'($urandom_range(0, 32'h000FFFFF)),
                                  31'($urandom_range(1, 32'h0FFFFFFF)), 31'($urandom));
            endcase
            case (ph % 4)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 67; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 67; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            for (int n = 0; n < 235; n++) begin
                if (ph == 4 && n == 120) drain();
                ch = 2'($urandom_range(0, Channels - 1));
                if ($urandom_range(99) < 25) begin
                    d = 16'($urandom);
                end else begin
                    step = int'(last_dist[ch]) + $urandom_range(0, 40) - 20;
                    if (step < 0) step = 0;
                    if (step > 65535) step = 65535;
                    d = 16'(step);
                end
                send(ch, d);
            end
        end

        req_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        $display("covered %0d requests, %0d results, over 8 register settings and", sent,
                 results);
        $display("four sender/receiver pacing modes; %0d mismatches", errors);
        if (errors == 0 && pending == 0)
            $display("kalman_range_tracker_unit_test OK");
        else
            $display("kalman_range_tracker_unit_test NOT OK");
        $finish;
    end
endmodule
